@@ src/afr_pkg.sv @@
// ---------------------------------------------------------------------------
// afr_pkg
// Shared constants, types, the CORDIC angle table and the coefficient
// multiply used by the azimuth/elevation frame rotation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package afr_pkg;

    localparam int ANGLE_BITS     = 32;
    localparam int COEF_FRAC_BITS = 30;
    localparam int CORDIC_STAGES  = 32;

    // Datapath width: room for angle accumulators and CORDIC growth.
    localparam int DW = (ANGLE_BITS + 4 > COEF_FRAC_BITS + 6) ?
                        ANGLE_BITS + 4 : COEF_FRAC_BITS + 6;
    localparam int STG_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    // Field and configuration port widths.
    localparam int FIELD_W   = 32;
    localparam int CFG_N     = 4;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = $clog2(CFG_N);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_REF_LON  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REF_LAT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SITE_LON = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SITE_LAT = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] REF_LON_RESET  = CFG_W'(-32'sd1347053648);
    localparam logic [CFG_W-1:0] REF_LAT_RESET  = CFG_W'(32'sd468830493);
    localparam logic [CFG_W-1:0] SITE_LON_RESET = CFG_W'(-32'sd1348074421);
    localparam logic [CFG_W-1:0] SITE_LAT_RESET = CFG_W'(32'sd470930534);

    typedef logic signed [DW-1:0] dat_t;

    // One CORDIC step's data. The flag is the half-turn fold in rotation
    // mode and the zero-vector mark in vectoring mode; aux rides along.
    typedef struct packed {
        dat_t x;
        dat_t y;
        dat_t z;
        logic flag;
        dat_t aux;
    } cordic_t;

    typedef dat_t atan_tab_t [CORDIC_STAGES];

    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [63:0] INV_GAIN_Q64   = 64'h9B74EDA8435E5A67;

    localparam dat_t INV_GAIN =
        dat_t'(((INV_GAIN_Q64 >> (63 - COEF_FRAC_BITS)) + 64'd1) >> 1);
    localparam dat_t HALF_TURN    = dat_t'(64'd1 << (ANGLE_BITS - 1));
    localparam dat_t QUARTER_TURN = dat_t'(64'd1 << (ANGLE_BITS - 2));
    localparam logic [2*DW-1:0] ROUND_HALF = (2*DW)'(1) << (COEF_FRAC_BITS - 1);

    // atan(2^-i) as a binary angle: integer power series in Q62 radians,
    // scaled by 1/(2*pi) and rounded. Evaluated at elaboration only.
    function automatic atan_tab_t build_atan();
        atan_tab_t    tab;
        longint       rad;
        logic [63:0]  term;
        logic [63:0]  urad;
        logic [127:0] prod;
        logic [63:0]  hi;
        int           e;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (i == 0) begin
                tab[i] = dat_t'(64'd1 << (ANGLE_BITS - 3));
            end else begin
                rad = 0;
                for (int k = 0; k < 32; k++) begin
                    e = i * (2 * k + 1);
                    if (e <= 62) begin
                        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                        if (k % 2 == 1) begin
                            rad = rad - longint'(term);
                        end else begin
                            rad = rad + longint'(term);
                        end
                    end
                end
                urad   = rad;
                prod   = {64'd0, urad} * {64'd0, INV_TWO_PI_Q64};
                hi     = prod[127:64];
                tab[i] = dat_t'(((hi >> (62 - ANGLE_BITS - 1)) + 64'd1) >> 1);
            end
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();

    // Signed coefficient product, rounded to nearest with halves away from zero.
    function automatic dat_t smulq(input dat_t a, input dat_t b);
        logic [DW-1:0]   ua;
        logic [DW-1:0]   ub;
        logic [2*DW-1:0] p;
        logic [DW-1:0]   r;
        ua = a[DW-1] ? DW'(-a) : DW'(a);
        ub = b[DW-1] ? DW'(-b) : DW'(b);
        p  = ua * ub;
        p  = p + ROUND_HALF;
        r  = p[COEF_FRAC_BITS +: DW];
        return (a[DW-1] ^ b[DW-1]) ? dat_t'(-r) : dat_t'(r);
    endfunction

    // Start vector of a sine/cosine rotation, folded into plus or minus 90 degrees.
    function automatic cordic_t rot_fold(input logic [ANGLE_BITS-1:0] theta);
        cordic_t c;
        dat_t    z;
        c.x    = INV_GAIN;
        c.y    = '0;
        c.aux  = '0;
        c.flag = 1'b0;
        z = DW'(signed'(theta));
        if (z > QUARTER_TURN) begin
            z      = z - HALF_TURN;
            c.flag = 1'b1;
        end else if (z < -QUARTER_TURN) begin
            z      = z + HALF_TURN;
            c.flag = 1'b1;
        end
        c.z = z;
        return c;
    endfunction

    // Start vector of an atan2, with a half-turn prefold for negative x.
    function automatic cordic_t vec_fold(input dat_t x, input dat_t y, input dat_t aux);
        cordic_t c;
        c.aux  = aux;
        c.flag = (x == '0) && (y == '0);
        if (x[DW-1]) begin
            c.x = -x;
            c.y = -y;
            c.z = HALF_TURN;
        end else begin
            c.x = x;
            c.y = y;
            c.z = '0;
        end
        return c;
    endfunction

    function automatic dat_t sc_cos(input cordic_t c);
        return c.flag ? -c.x : c.x;
    endfunction

    function automatic dat_t sc_sin(input cordic_t c);
        return c.flag ? -c.y : c.y;
    endfunction

endpackage

@@ src/afr_if.sv @@
// ---------------------------------------------------------------------------
// afr_if
// Valid/ready channels for pointing requests and rotated results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface afr_in_if import afr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FIELD_W-1:0]        azimuth_in;
    logic signed [FIELD_W-1:0] elevation_in;

    modport source (output valid, output azimuth_in, output elevation_in, input ready);
    modport sink (input valid, input azimuth_in, input elevation_in, output ready);
endinterface

interface afr_out_if import afr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FIELD_W-1:0]        azimuth_out;
    logic signed [FIELD_W-1:0] elevation_out;

    modport source (output valid, output azimuth_out, output elevation_out, input ready);
    modport sink (input valid, input azimuth_out, input elevation_out, output ready);
endinterface

@@ src/afr_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// afr_cordic_cell
// One registered CORDIC micro-rotation, in rotation or vectoring mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module afr_cordic_cell import afr_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic             vectoring,
    input  logic [STG_W-1:0] stage,
    input  cordic_t          d,
    output cordic_t          q
);

    cordic_t q_reg;
    cordic_t q_next;
    dat_t    xs;
    dat_t    ys;
    logic    plus;

    always_comb
    begin
        xs   = d.x >>> stage;
        ys   = d.y >>> stage;
        // Rotation drives z toward zero, vectoring drives y toward zero.
        plus = vectoring ? d.y[DW-1] : !d.z[DW-1];
        q_next = d;
        if (plus)
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - ATAN_TAB[stage];
        end
        else
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + ATAN_TAB[stage];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ src/afr_cordic_chain.sv @@
// ---------------------------------------------------------------------------
// afr_cordic_chain
// A row of registered CORDIC cells, one per stage, all held while en is low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module afr_cordic_chain import afr_pkg::*; (
    input  logic    clk,
    input  logic    en,
    input  logic    vectoring,
    input  cordic_t d,
    output cordic_t q
);

    cordic_t link [CORDIC_STAGES+1];

    assign link[0] = d;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        afr_cordic_cell u_cell (
            .clk       (clk),
            .en        (en),
            .vectoring (vectoring),
            .stage     (STG_W'(g)),
            .d         (link[g]),
            .q         (link[g+1])
        );
    end

    assign q = link[CORDIC_STAGES];

endmodule

@@ src/afr_matrix.sv @@
// ---------------------------------------------------------------------------
// afr_matrix
// Configuration registers and the combined site-to-reference rotation matrix.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module afr_matrix import afr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output dat_t                 matrix [3][3],
    output logic                 settled
);

    localparam int SETTLE = CORDIC_STAGES + 3;
    localparam int CNT_W  = $clog2(SETTLE + 1);

    logic [CFG_W-1:0] ref_lon_reg;
    logic [CFG_W-1:0] ref_lat_reg;
    logic [CFG_W-1:0] site_lon_reg;
    logic [CFG_W-1:0] site_lat_reg;
    logic [CNT_W-1:0] settle_reg;

    cordic_t chain_d [4];
    cordic_t chain_q [4];

    dat_t sl [2];
    dat_t cl [2];
    dat_t sp [2];
    dat_t cp [2];

    dat_t fr_reg   [2][3][3];
    dat_t prod_reg [3][3][3];
    dat_t mat_reg  [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lon_reg  <= REF_LON_RESET;
            ref_lat_reg  <= REF_LAT_RESET;
            site_lon_reg <= SITE_LON_RESET;
            site_lat_reg <= SITE_LAT_RESET;
            settle_reg   <= CNT_W'(SETTLE);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REF_LON:  ref_lon_reg  <= cfg_data;
                    REG_REF_LAT:  ref_lat_reg  <= cfg_data;
                    REG_SITE_LON: site_lon_reg <= cfg_data;
                    REG_SITE_LAT: site_lat_reg <= cfg_data;
                    default:      ;
                endcase
            end
            // The matrix pipeline runs freely; wait for a new setting to reach its end.
            if (cfg_we)
            begin
                settle_reg <= CNT_W'(SETTLE);
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - CNT_W'(1);
            end
        end
    end

    assign chain_d[0] = rot_fold(ANGLE_BITS'(ref_lon_reg));
    assign chain_d[1] = rot_fold(ANGLE_BITS'(ref_lat_reg));
    assign chain_d[2] = rot_fold(ANGLE_BITS'(site_lon_reg));
    assign chain_d[3] = rot_fold(ANGLE_BITS'(site_lat_reg));

    for (genvar c = 0; c < 4; c++)
    begin : g_chain
        afr_cordic_chain u_chain (
            .clk       (clk),
            .en        (1'b1),
            .vectoring (1'b0),
            .d         (chain_d[c]),
            .q         (chain_q[c])
        );
    end

    always_comb
    begin
        for (int f = 0; f < 2; f++)
        begin
            sl[f] = sc_sin(chain_q[2*f]);
            cl[f] = sc_cos(chain_q[2*f]);
            sp[f] = sc_sin(chain_q[2*f+1]);
            cp[f] = sc_cos(chain_q[2*f+1]);
        end
    end

    // Columns are the east, north and up unit vectors of each frame.
    always_ff @(posedge clk)
    begin
        for (int f = 0; f < 2; f++)
        begin
            fr_reg[f][0][0] <= -sl[f];
            fr_reg[f][1][0] <= cl[f];
            fr_reg[f][2][0] <= '0;
            fr_reg[f][0][1] <= -smulq(sp[f], cl[f]);
            fr_reg[f][1][1] <= -smulq(sp[f], sl[f]);
            fr_reg[f][2][1] <= cp[f];
            fr_reg[f][0][2] <= smulq(cp[f], cl[f]);
            fr_reg[f][1][2] <= smulq(cp[f], sl[f]);
            fr_reg[f][2][2] <= sp[f];
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[i][j][k] <= smulq(fr_reg[1][k][i], fr_reg[0][k][j]);
                end
                mat_reg[i][j] <= prod_reg[i][j][0] + prod_reg[i][j][1] + prod_reg[i][j][2];
            end
        end
    end

    assign matrix  = mat_reg;
    assign settled = (settle_reg == '0);

endmodule

@@ src/azel_frame_rotation.sv @@
// ---------------------------------------------------------------------------
// azel_frame_rotation
// Pointing requests arrive on the pointing channel as azimuth and elevation in
// the source site's east-north-up frame; each leaves on the rotated channel as
// azimuth and elevation in the reference site's frame, in request order.
// Four registers on the write port set the two frames' longitude and latitude.
// Throughput is one request per cycle while the receiver keeps up and the
// matrix has settled. Each request passes three CORDIC cell rows: sine/cosine
// of the input angles, the azimuth atan2 and the elevation atan2, plus five
// further register stages. The rotation matrix comes from a free-running
// pipeline of its own; after reset and after every register write,
// pointing.ready stays low while the new matrix settles.
// When the receiver stalls, the whole pipeline holds and ready drops only if a
// result is waiting in the output register; bubbles are not squeezed out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module azel_frame_rotation import afr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    afr_in_if.sink               pointing,
    afr_out_if.source            rotated
);

    localparam int LAT = 3 * CORDIC_STAGES + 5;

    logic             adv;
    logic             settled;
    logic [LAT-1:0]   vld_reg;
    dat_t             matrix [3][3];

    cordic_t az_d;
    cordic_t az_q;
    cordic_t el_d;
    cordic_t el_q;
    cordic_t h_d;
    cordic_t h_q;
    cordic_t e_d;
    cordic_t e_q;

    dat_t v_reg  [3];
    dat_t wp_reg [3][3];
    dat_t w_reg  [3];
    dat_t rh_reg;
    dat_t w2_reg;
    logic [FIELD_W-1:0] azr_reg;
    logic [FIELD_W-1:0] az_out_reg;
    logic [FIELD_W-1:0] el_out_reg;
    dat_t el_next;

    assign adv            = !vld_reg[LAT-1] || rotated.ready;
    assign pointing.ready = adv && settled;

    afr_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .matrix    (matrix),
        .settled   (settled)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], pointing.valid && pointing.ready};
        end
    end

    // Sine and cosine of the input azimuth and elevation.
    assign az_d = rot_fold(ANGLE_BITS'(pointing.azimuth_in));
    assign el_d = rot_fold(ANGLE_BITS'(pointing.elevation_in));

    afr_cordic_chain u_az_chain (
        .clk (clk), .en (adv), .vectoring (1'b0), .d (az_d), .q (az_q)
    );

    afr_cordic_chain u_el_chain (
        .clk (clk), .en (adv), .vectoring (1'b0), .d (el_d), .q (el_q)
    );

    // Unit vector, then its rotation by the frame matrix.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg[0] <= smulq(sc_cos(el_q), sc_cos(az_q));
            v_reg[1] <= smulq(sc_cos(el_q), sc_sin(az_q));
            v_reg[2] <= sc_sin(el_q);
            for (int j = 0; j < 3; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    wp_reg[j][i] <= smulq(matrix[i][j], v_reg[i]);
                end
                w_reg[j] <= wp_reg[j][0] + wp_reg[j][1] + wp_reg[j][2];
            end
        end
    end

    // Azimuth: atan2 of north over east; the up component rides along.
    assign h_d = vec_fold(w_reg[0], w_reg[1], w_reg[2]);

    afr_cordic_chain u_h_chain (
        .clk (clk), .en (adv), .vectoring (1'b1), .d (h_d), .q (h_q)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rh_reg  <= smulq(h_q.x, INV_GAIN);
            w2_reg  <= h_q.aux;
            azr_reg <= h_q.flag ? '0 : FIELD_W'(h_q.z);
        end
    end

    // Elevation: atan2 of up over the gain-corrected horizontal magnitude.
    assign e_d = vec_fold(rh_reg, w2_reg, DW'(azr_reg));

    afr_cordic_chain u_e_chain (
        .clk (clk), .en (adv), .vectoring (1'b1), .d (e_d), .q (e_q)
    );

    always_comb
    begin
        el_next = e_q.flag ? '0 : e_q.z;
        if (el_next > QUARTER_TURN)
        begin
            el_next = QUARTER_TURN;
        end
        else if (el_next < -QUARTER_TURN)
        begin
            el_next = -QUARTER_TURN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            az_out_reg <= FIELD_W'(e_q.aux);
            el_out_reg <= FIELD_W'(el_next);
        end
    end

    assign rotated.valid         = vld_reg[LAT-1];
    assign rotated.azimuth_out   = az_out_reg;
    assign rotated.elevation_out = el_out_reg;

endmodule

@@ bench/azel_frame_rotation_test.sv @@
// ---------------------------------------------------------------------------
// azel_frame_rotation_test
// Drives pointing requests through the frame rotation under several frame
// settings, with bursty input and a stalling receiver. A bit-exact CORDIC
// predictor computes every rotated direction, which is checked field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module azel_frame_rotation_test;
    import afr_pkg::*;

    localparam int  RANDOM_REQUESTS = 1600;
    localparam int  DRAIN_CYCLES    = 120;
    localparam longint CYCLE_LIMIT  = 600000;
    localparam longint FULL   = 64'sd1 << 32;
    localparam longint HALF   = 64'sd1 << 31;
    localparam longint QUART  = 64'sd1 << 30;

    typedef struct {
        logic [31:0] azimuth;
        logic [31:0] elevation;
    } direction_t;

    // Bit-exact model of the rotation and the queue of directions in flight.
    class rotation_predictor;
        logic [31:0] frame_reg [4];
        longint      atan_step [32];
        direction_t  in_flight [$];
        int          mismatches;
        int          checked;

        function void reset_regs();
            frame_reg[REG_REF_LON]  = REF_LON_RESET;
            frame_reg[REG_REF_LAT]  = REF_LAT_RESET;
            frame_reg[REG_SITE_LON] = SITE_LON_RESET;
            frame_reg[REG_SITE_LAT] = SITE_LAT_RESET;
        endfunction

        function void fill_atan();
            longint      rad;
            logic [63:0] term;
            logic [127:0] prod;
            logic [63:0] hi;
            int          e;
            atan_step[0] = 64'sd1 << 29;
            for (int i = 1; i < 32; i++)
            begin
                rad = 0;
                for (int k = 0; i * (2 * k + 1) <= 62; k++)
                begin
                    e = i * (2 * k + 1);
                    term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                    rad = (k % 2 == 1) ? rad - longint'(term) : rad + longint'(term);
                end
                prod = {64'd0, 64'(rad)} * {64'd0, 64'h28BE60DB9391054A};
                hi = prod[127:64];
                atan_step[i] = longint'(((hi >> 29) + 64'd1) >> 1);
            end
        endfunction

        function longint gain_comp();
            return longint'(((64'h9B74EDA8435E5A67 >> 33) + 64'd1) >> 1);
        endfunction

        // Q1.30 product, rounded to nearest with halves away from zero.
        function longint qmul(longint a, longint b);
            logic [63:0]  ua;
            logic [63:0]  ub;
            logic [127:0] p;
            logic [63:0]  r;
            ua = (a < 0) ? 64'(-a) : 64'(a);
            ub = (b < 0) ? 64'(-b) : 64'(b);
            p = {64'd0, ua} * {64'd0, ub};
            p = p + (128'd1 << 29);
            r = p[93:30];
            r[63:62] = 2'b00;
            return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
        endfunction

        function void sin_cos(logic [31:0] theta, output longint s, output longint c);
            longint z;
            longint x;
            longint y;
            longint nx;
            bit     flip;
            z = longint'(theta);
            x = gain_comp();
            y = 0;
            flip = 0;
            if (z >= HALF) z -= FULL;
            if (z > QUART)
            begin
                z -= HALF;
                flip = 1;
            end
            else if (z < -QUART)
            begin
                z += HALF;
                flip = 1;
            end
            for (int i = 0; i < 32; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= atan_step[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += atan_step[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint arc_of(longint x, longint y, output longint mag);
            longint z;
            longint nx;
            z = 0;
            mag = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = HALF;
            end
            for (int i = 0; i < 32; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += atan_step[i];
                end
                else
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= atan_step[i];
                end
                x = nx;
            end
            mag = x;
            return z;
        endfunction

        // Columns are the east, north and up axes of a frame in global terms.
        function void enu_axes(logic [31:0] lon, logic [31:0] lat, output longint m [3][3]);
            longint sl;
            longint cl;
            longint sp;
            longint cp;
            sin_cos(lon, sl, cl);
            sin_cos(lat, sp, cp);
            m[0][0] = -sl;              m[1][0] = cl;               m[2][0] = 0;
            m[0][1] = -qmul(sp, cl);    m[1][1] = -qmul(sp, sl);    m[2][1] = cp;
            m[0][2] = qmul(cp, cl);     m[1][2] = qmul(cp, sl);     m[2][2] = sp;
        endfunction

        function direction_t rotate(logic [31:0] az, logic [31:0] el);
            longint rr [3][3];
            longint rs [3][3];
            longint m [3][3];
            longint v [3];
            longint w [3];
            longint sa;
            longint ca;
            longint se;
            longint ce;
            longint mag;
            longint a;
            longint e;
            direction_t d;
            enu_axes(frame_reg[REG_REF_LON], frame_reg[REG_REF_LAT], rr);
            enu_axes(frame_reg[REG_SITE_LON], frame_reg[REG_SITE_LAT], rs);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    m[i][j] = 0;
                    for (int k = 0; k < 3; k++) m[i][j] += qmul(rs[k][i], rr[k][j]);
                end
            sin_cos(az, sa, ca);
            sin_cos(el, se, ce);
            v[0] = qmul(ce, ca);
            v[1] = qmul(ce, sa);
            v[2] = se;
            for (int j = 0; j < 3; j++)
            begin
                w[j] = 0;
                for (int i = 0; i < 3; i++) w[j] += qmul(m[i][j], v[i]);
            end
            a = arc_of(w[0], w[1], mag);
            e = arc_of(qmul(mag, gain_comp()), w[2], mag);
            if (e > QUART) e = QUART;
            if (e < -QUART) e = -QUART;
            d.azimuth = a[31:0];
            d.elevation = e[31:0];
            return d;
        endfunction

        function void note_request(logic [31:0] az, logic [31:0] el);
            in_flight.push_back(rotate(az, el));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("MISMATCH result %0d: %s got %08h expected %08h", checked, what, got, want);
        endtask

        task check_result(logic [31:0] az, logic [31:0] el);
            direction_t d;
            if (in_flight.size() == 0)
            begin
                report("unexpected result, azimuth", az, 32'h0);
                return;
            end
            d = in_flight.pop_front();
            if (az !== d.azimuth) report("azimuth", az, d.azimuth);
            if (el !== d.elevation) report("elevation", el, d.elevation);
            checked++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    longint               cycles;
    int                   accepted;
    int                   stall_pct;
    int                   phases;
    rotation_predictor    model;

    afr_in_if  pointing ();
    afr_out_if rotated ();

    azel_frame_rotation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pointing  (pointing.sink),
        .rotated   (rotated.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    initial
    begin
        while (cycles < CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off once traffic is well under way.
    initial
    begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        rotated.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && accepted >= 600)
            begin
                held = 1;
                hold = 400;
            end
            if (hold > 0)
            begin
                hold--;
                rotated.ready <= 1'b0;
            end
            else
                rotated.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && rotated.valid && rotated.ready)
            model.check_result(rotated.azimuth_out, rotated.elevation_out);

    task send_request(logic [31:0] az, logic [31:0] el);
        @(negedge clk);
        pointing.valid <= 1'b1;
        pointing.azimuth_in <= az;
        pointing.elevation_in <= el;
        do @(posedge clk); while (!pointing.ready);
        model.note_request(az, el);
        accepted++;
    endtask

    task pause_input(int n);
        @(negedge clk);
        pointing.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task settle_idle();
        pause_input(0);
        while (model.in_flight.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        model.frame_reg[idx] = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task set_frames(logic [31:0] rlon, logic [31:0] rlat, logic [31:0] slon, logic [31:0] slat);
        settle_idle();
        write_reg(REG_REF_LON, rlon);
        write_reg(REG_REF_LAT, rlat);
        write_reg(REG_SITE_LON, slon);
        write_reg(REG_SITE_LAT, slat);
        phases++;
    endtask

    function logic [31:0] any_latitude();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'($urandom_range(32'h8000_0000) - 32'h4000_0000);
    endfunction

    function logic [31:0] any_elevation();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) return $urandom;
        if (pick == 1) return $urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000;
        return 32'($urandom_range(32'h8000_0000) - 32'h4000_0000);
    endfunction

    task directed_requests();
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'h4000_0000, 32'h4000_0000);
        send_request(32'h8000_0000, 32'hC000_0000);
        send_request(32'hC000_0000, 32'h2000_0000);
        send_request(32'h7FFF_FFFF, 32'hE000_0000);
        send_request(32'h8000_0001, 32'h3FFF_FFFF);
        // Elevations outside plus or minus a quarter turn are ordinary angles.
        send_request(32'h1234_5678, 32'h8000_0000);
        send_request(32'h2000_0000, 32'h7FFF_FFFF);
        send_request(32'h6000_0000, 32'h4000_0001);
        send_request(32'hA000_0000, 32'hBFFF_FFFF);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    // Bursts of random length with random gaps; some stretches run gap-free.
    task random_requests(int count);
        int sent;
        int burst;
        bit no_gaps;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            no_gaps = ($urandom_range(3) == 0);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_request($urandom, any_elevation());
                sent++;
            end
            if (!no_gaps) pause_input($urandom_range(0, 8));
        end
    endtask

    initial
    begin
        model = new();
        model.fill_atan();
        model.reset_regs();
        accepted = 0;
        phases = 0;
        stall_pct = 0;
        cfg_we = 1'b0;
        cfg_index = REG_REF_LON;
        cfg_data = '0;
        pointing.valid = 1'b0;
        pointing.azimuth_in = '0;
        pointing.elevation_in = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_requests();
        stall_pct = 30;
        random_requests(700);

        // Identical frames: the rotation is nearly the identity, straight up included.
        set_frames(32'h0, 32'h0, 32'h0, 32'h0);
        stall_pct = 0;
        directed_requests();
        send_request(32'h0, 32'h4000_0000);

        set_frames(32'h8000_0000, 32'h4000_0000, 32'h7FFF_FFFF, 32'hC000_0000);
        stall_pct = 60;
        directed_requests();
        random_requests(250);

        set_frames(32'h7FFF_FFFF, 32'hC000_0000, 32'h8000_0000, 32'h4000_0000);
        stall_pct = 10;
        random_requests(250);

        for (int p = 0; p < 3; p++)
        begin
            set_frames($urandom, any_latitude(), $urandom, any_latitude());
            stall_pct = $urandom_range(0, 70);
            random_requests(150);
        end

        settle_idle();
        $display("Covered %0d requests over %0d frame settings, with bursty input,",
                 accepted, phases + 1);
        $display("receiver stalls and one long hold-off; %0d results checked.", model.checked);
        if (model.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
